### rtl/core/sdfl_pkg.sv
package sdfl_pkg;

  localparam int MAX_SLOTS_DEF   = 512;
  localparam int OFFSET_BITS_DEF = 14;

  localparam int REQ_W    = 3;
  localparam int INDEX_W  = 9;
  localparam int OFFSET_W = 14;
  localparam int STATUS_W = 2;
  localparam int RIDX_W   = 10;
  localparam int COUNT_W  = 10;
  localparam int CMP_W    = 18;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR    = 3'd0,
    REQ_ALLOC    = 3'd1,
    REQ_INSERT   = 3'd2,
    REQ_RELEASE  = 3'd3,
    REQ_REMOVE   = 3'd4,
    REQ_FIND     = 3'd5,
    REQ_SET      = 3'd6,
    REQ_READLINK = 3'd7
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_MISMATCH = 2'd1,
    STS_RANGE    = 2'd2,
    STS_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_SHIFT_DN,
    ST_SHIFT_UP,
    ST_FIND
  } state_t;

endpackage

### rtl/core/sdfl_ram.sv
module sdfl_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/slot_directory_free_list.sv
// Clear and append-alloc answer straight from the execute state; requests that
// check an entry pass through a check state first.
// Insert, remove and find walk the entry memory (one read port, one write port)
// one entry a cycle, so a new request is taken only after the last one is done.
// Results cannot be stalled; busy is high from accept until the strobe.
// Synchronous reset empties the directory and the unused list; entries stay.
module slot_directory_free_list #(
  parameter int MAX_SLOTS   = sdfl_pkg::MAX_SLOTS_DEF,
  parameter int OFFSET_BITS = sdfl_pkg::OFFSET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [sdfl_pkg::REQ_W-1:0]    in_req_type,
  input  logic [sdfl_pkg::INDEX_W-1:0]  in_slot_index,
  input  logic [sdfl_pkg::OFFSET_W-1:0] in_slot_offset,
  output logic                          out_strobe,
  output logic [sdfl_pkg::STATUS_W-1:0] out_status,
  output logic [sdfl_pkg::RIDX_W-1:0]   out_result_index,
  output logic                          out_found,
  output logic [sdfl_pkg::OFFSET_W-1:0] out_result_offset,
  output logic [sdfl_pkg::COUNT_W-1:0]  out_entry_count,
  output logic                          out_has_unused
);

  import sdfl_pkg::*;

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int EW = OFFSET_BITS + 1;
  localparam logic [OFFSET_BITS-1:0] INVALID = {OFFSET_BITS{1'b1}};

  state_t                 state_r, state_nxt;
  req_t                   req_r;
  logic [INDEX_W-1:0]     idx_r;
  logic [OFFSET_BITS-1:0] offs_r;
  logic [CW-1:0]          count_r, count_nxt;
  logic [OFFSET_BITS-1:0] head_r, head_nxt;
  logic [AW-1:0]          ptr_r, ptr_nxt, last_r, last_nxt;
  logic [CW-1:0]          rem_r, rem_nxt;
  logic                   pend_r, pend_nxt;

  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  logic [EW-1:0]          wdata, rdata;

  logic                   rsp_vld;
  status_t                rsp_status;
  logic [CMP_W-1:0]       rsp_ridx;
  logic                   rsp_found;
  logic [OFFSET_BITS-1:0] rsp_link;

  logic [CMP_W-1:0] idx_x, cnt_x, head_x, inv_x, max_x;
  logic             rd_unused;
  logic [OFFSET_BITS-1:0] rd_offs;

  assign idx_x     = CMP_W'(idx_r);
  assign cnt_x     = CMP_W'(count_r);
  assign head_x    = CMP_W'(head_r);
  assign inv_x     = CMP_W'(INVALID);
  assign max_x     = CMP_W'(MAX_SLOTS);
  assign rd_unused = rdata[EW-1];
  assign rd_offs   = rdata[OFFSET_BITS-1:0];
  assign busy      = (state_r != ST_IDLE);

  sdfl_ram #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (EW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      head_r     <= INVALID;
      pend_r     <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      head_r     <= head_nxt;
      pend_r     <= pend_nxt;
      out_strobe <= rsp_vld;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    last_r <= last_nxt;
    rem_r  <= rem_nxt;
    if (start && !busy) begin
      req_r  <= req_t'(in_req_type);
      idx_r  <= in_slot_index;
      offs_r <= OFFSET_BITS'(in_slot_offset);
    end
    if (rsp_vld) begin
      out_status        <= rsp_status;
      out_result_index  <= RIDX_W'(rsp_ridx);
      out_found         <= rsp_found;
      out_result_offset <= OFFSET_W'(rsp_link);
      out_entry_count   <= COUNT_W'(count_nxt);
      out_has_unused    <= (head_nxt != INVALID);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    head_nxt   = head_r;
    ptr_nxt    = ptr_r;
    last_nxt   = last_r;
    rem_nxt    = rem_r;
    pend_nxt   = pend_r;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    raddr      = ptr_r;
    rsp_vld    = 1'b0;
    rsp_status = STS_OK;
    rsp_ridx   = '0;
    rsp_found  = 1'b0;
    rsp_link   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        raddr = AW'(idx_r);
        unique case (req_r)
          REQ_CLEAR: begin
            count_nxt = '0;
            head_nxt  = INVALID;
            rsp_vld   = 1'b1;
            state_nxt = ST_IDLE;
          end
          REQ_ALLOC: begin
            if (head_r == INVALID) begin
              if (cnt_x >= max_x) begin
                rsp_status = STS_FULL;
              end else begin
                we        = 1'b1;
                waddr     = AW'(count_r);
                wdata     = {1'b0, offs_r};
                rsp_ridx  = cnt_x;
                count_nxt = count_r + 1'b1;
              end
              rsp_vld   = 1'b1;
              state_nxt = ST_IDLE;
            end else if (head_x >= cnt_x) begin
              rsp_status = STS_RANGE;
              rsp_vld    = 1'b1;
              state_nxt  = ST_IDLE;
            end else begin
              raddr     = AW'(head_r);
              state_nxt = ST_CHECK;
            end
          end
          REQ_INSERT: begin
            if (idx_x > cnt_x) begin
              rsp_status = STS_RANGE;
              rsp_vld    = 1'b1;
              state_nxt  = ST_IDLE;
            end else if (cnt_x >= max_x) begin
              rsp_status = STS_FULL;
              rsp_vld    = 1'b1;
              state_nxt  = ST_IDLE;
            end else begin
              ptr_nxt   = AW'(cnt_x - 1'b1);
              rem_nxt   = CW'(cnt_x - idx_x);
              pend_nxt  = 1'b0;
              state_nxt = ST_SHIFT_DN;
            end
          end
          REQ_FIND: begin
            if (count_r == '0) begin
              rsp_vld   = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              ptr_nxt   = '0;
              rem_nxt   = count_r;
              pend_nxt  = 1'b0;
              state_nxt = ST_FIND;
            end
          end
          default: begin
            if (idx_x >= cnt_x || (req_r == REQ_RELEASE && idx_x >= inv_x)) begin
              rsp_status = STS_RANGE;
              rsp_vld    = 1'b1;
              state_nxt  = ST_IDLE;
            end else begin
              state_nxt = ST_CHECK;
            end
          end
        endcase
      end
      ST_CHECK: begin
        state_nxt = ST_IDLE;
        rsp_vld   = 1'b1;
        priority if ((req_r == REQ_ALLOC || req_r == REQ_READLINK) != rd_unused) begin
          rsp_status = STS_MISMATCH;
        end else if (req_r == REQ_ALLOC) begin
          we       = 1'b1;
          waddr    = AW'(head_r);
          wdata    = {1'b0, offs_r};
          rsp_ridx = head_x;
          head_nxt = rd_offs;
        end else if (req_r == REQ_RELEASE) begin
          we       = 1'b1;
          waddr    = AW'(idx_r);
          wdata    = {1'b1, head_r};
          head_nxt = OFFSET_BITS'(idx_r);
        end else if (req_r == REQ_SET) begin
          we    = 1'b1;
          waddr = AW'(idx_r);
          wdata = {1'b0, offs_r};
        end else if (req_r == REQ_READLINK) begin
          rsp_link = rd_offs;
        end else begin
          rsp_vld   = 1'b0;
          ptr_nxt   = AW'(idx_x + 1'b1);
          rem_nxt   = CW'(cnt_x - idx_x - 1'b1);
          pend_nxt  = 1'b0;
          state_nxt = ST_SHIFT_UP;
        end
      end
      ST_SHIFT_DN, ST_SHIFT_UP: begin
        we    = pend_r;
        waddr = (state_r == ST_SHIFT_DN) ? last_r + 1'b1 : last_r - 1'b1;
        wdata = rdata;
        if (rem_r != '0) begin
          last_nxt = ptr_r;
          ptr_nxt  = (state_r == ST_SHIFT_DN) ? ptr_r - 1'b1 : ptr_r + 1'b1;
          rem_nxt  = rem_r - 1'b1;
          pend_nxt = 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          rsp_vld   = 1'b1;
          state_nxt = ST_IDLE;
          if (state_r == ST_SHIFT_DN) begin
            we        = 1'b1;
            waddr     = AW'(idx_r);
            wdata     = {1'b0, offs_r};
            rsp_ridx  = idx_x;
            count_nxt = count_r + 1'b1;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      ST_FIND: begin
        if (pend_r && rd_offs == offs_r) begin
          rsp_vld    = 1'b1;
          state_nxt  = ST_IDLE;
          rsp_ridx   = CMP_W'(last_r);
          rsp_found  = !rd_unused;
          rsp_status = rd_unused ? STS_MISMATCH : STS_OK;
        end else if (rem_r != '0) begin
          last_nxt = ptr_r;
          ptr_nxt  = ptr_r + 1'b1;
          rem_nxt  = rem_r - 1'b1;
          pend_nxt = 1'b1;
        end else begin
          rsp_vld   = 1'b1;
          state_nxt = ST_IDLE;
          rsp_ridx  = cnt_x;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("request finished without a result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(MAX_SLOTS))
    else $error("entry count beyond table size");
`endif

endmodule
